>>> hw/rtl/box_blur_3x3_border_clamped_defines.svh
// assertion macros for the 3x3 box blur
// used by the top level only; expects clk and rst_n in scope
`ifndef BOX_BLUR_3X3_BORDER_CLAMPED_DEFINES_SVH
`define BOX_BLUR_3X3_BORDER_CLAMPED_DEFINES_SVH

// same-cycle implication
`define BB3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BB3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/bb3_pkg.sv
// shared types, constants and divide helper for the 3x3 box blur
// no dependencies
package bb3_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int FW_W          = 11;
  localparam int FH_W          = 12;
  localparam int ROW_W         = 12;
  localparam int OCOL_W        = 10;
  localparam int CFG_DATA_W    = 12;
  localparam int CFG_IDX_W     = 2;
  localparam int SUM_W         = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALVE_MODE   = 2'd2;

  localparam logic [FW_W-1:0] FW_RESET = 11'd640;
  localparam logic [FH_W-1:0] FH_RESET = 12'd480;

  // neighbourhood sizes
  localparam logic [1:0] CNT4 = 2'd0;
  localparam logic [1:0] CNT6 = 2'd1;
  localparam logic [1:0] CNT9 = 2'd2;

  typedef logic [23:0] pix_t;
  // [0] two rows up, [1] one row up, [2] current row
  typedef pix_t [2:0] col_t;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]        out_red;
    logic [7:0]        out_green;
    logic [7:0]        out_blue;
    logic [OCOL_W-1:0] out_col;
    logic [ROW_W-1:0]  out_row;
    logic              last_of_run;
    logic              end_of_frame;
  } pix_out_t;

  typedef struct packed {
    logic              use_a;
    logic              first;
    logic              halve;
    logic [OCOL_W-1:0] col;
    logic [ROW_W-1:0]  row;
    logic              last;
    logic              eof;
  } mean_req_t;

  // floor(v/count) by reciprocal, exact while v is at most 255 times the count
  function automatic logic [7:0] div_cnt(input logic [SUM_W-1:0] v, input logic [1:0] code);
    logic [25:0] p6;
    logic [25:0] p9;
    logic [7:0]  q;
    p6 = 26'(v) * 26'd10923;
    p9 = 26'(v) * 26'd3641;
    case (code)
      CNT4:    q = v[9:2];
      CNT6:    q = p6[23:16];
      CNT9:    q = p9[22:15];
      default: q = v[9:2];
    endcase
    return q;
  endfunction

endpackage

>>> hw/rtl/box_blur_3x3_border_clamped.sv
// channel  | direction | beat
// in_      | in        | one raster-order rgb pixel
// out_     | out       | one blurred pixel with its position and flags
// cfg_     | in        | register write, no read-back
// each pixel passes through accept and line store read, write-back, four job
// slots and window shift, and no new pixel is taken until it is done; the
// single-port sum/divide unit sets the job pace
// rst_n is synchronous; the line stores hold garbage until written
// a stalled output holds the sum stage, which holds the job sequencer
// depends on bb3_pkg, bb3_ram, bb3_mean and the defines header
`include "box_blur_3x3_border_clamped_defines.svh"

module box_blur_3x3_border_clamped #(
  parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bb3_pkg::pix_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bb3_pkg::pix_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = ((CW > bb3_pkg::FW_W) ? CW : bb3_pkg::FW_W) + 1;
  localparam logic [EW-1:0] MAXW = EW'(MAX_WIDTH);
  localparam int RW = bb3_pkg::ROW_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_JOB  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic [1:0]                 job_r, job_nxt;
  logic [CW-1:0]              col_r;
  logic [RW-1:0]              row_r;
  bb3_pkg::col_t              win_a_r, win_b_r;
  bb3_pkg::pix_t              pix_r;
  logic [bb3_pkg::FW_W-1:0]   fw_r;
  logic [bb3_pkg::FH_W-1:0]   fh_r;
  logic                       halve_r;

  logic                       accept;
  logic [EW-1:0]              weff, col_e;
  logic [bb3_pkg::FH_W-1:0]   heff;
  logic                       last_col, last_row, r1, c1, c2;
  logic [3:0]                 en;
  logic                       job_en, start, mean_rdy;
  bb3_pkg::mean_req_t         req;
  bb3_pkg::pix_t              older_rd, newer_rd;
  bb3_pkg::col_t              cur;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r    <= bb3_pkg::FW_RESET;
      fh_r    <= bb3_pkg::FH_RESET;
      halve_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        bb3_pkg::CFG_FRAME_WIDTH:  fw_r    <= cfg_wdata[bb3_pkg::FW_W-1:0];
        bb3_pkg::CFG_FRAME_HEIGHT: fh_r    <= cfg_wdata[bb3_pkg::FH_W-1:0];
        bb3_pkg::CFG_HALVE_MODE:   halve_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  always_comb begin
    if (EW'(fw_r) < EW'(2)) begin
      weff = EW'(2);
    end else if (EW'(fw_r) > MAXW) begin
      weff = MAXW;
    end else begin
      weff = EW'(fw_r);
    end
    heff     = (fh_r < bb3_pkg::FH_W'(2)) ? bb3_pkg::FH_W'(2) : fh_r;
    col_e    = EW'(col_r);
    last_col = (col_e >= weff - EW'(1));
    last_row = (row_r >= heff - bb3_pkg::FH_W'(1));
    r1       = (row_r != '0);
    c1       = (col_r != '0);
    c2       = (col_e >= EW'(2));
    en[0]    = r1 && c1;
    en[1]    = r1 && last_col;
    en[2]    = r1 && last_row && c1;
    en[3]    = r1 && last_row && last_col;
  end

  // line stores
  bb3_ram #(.W(24), .DEPTH(MAX_WIDTH)) u_older (
    .clk   (clk),
    .we    (state_r == S_READ),
    .waddr (col_r),
    .wdata (newer_rd),
    .re    (accept),
    .raddr (col_r),
    .rdata (older_rd)
  );

  bb3_ram #(.W(24), .DEPTH(MAX_WIDTH)) u_newer (
    .clk   (clk),
    .we    (state_r == S_READ),
    .waddr (col_r),
    .wdata (pix_r),
    .re    (accept),
    .raddr (col_r),
    .rdata (newer_rd)
  );

  always_comb begin
    cur[0] = older_rd;
    cur[1] = newer_rd;
    cur[2] = pix_r;
  end

  // job request: bit 0 picks the right-edge column, bit 1 the last-row copy
  always_comb begin
    req.use_a = !job_r[0] && c2;
    req.first = job_r[1] || (row_r < RW'(2));
    req.halve = halve_r;
    req.col   = job_r[0] ? bb3_pkg::OCOL_W'(col_r) : bb3_pkg::OCOL_W'(col_r - CW'(1));
    req.row   = job_r[1] ? row_r : row_r - RW'(1);
    req.last  = ((en >> job_r) == 4'b0001);
    req.eof   = (job_r == 2'd3);
  end

  assign job_en = en[job_r];
  assign start  = (state_r == S_JOB) && job_en && mean_rdy;

  bb3_mean u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (req),
    .col_a     (win_a_r),
    .col_b     (win_b_r),
    .col_c     (cur),
    .ready     (mean_rdy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_JOB;
        job_nxt   = 2'd0;
      end
      S_JOB: begin
        if (!job_en || mean_rdy) begin
          if (job_r == 2'd3) begin
            state_nxt = S_DONE;
          end else begin
            job_nxt = job_r + 2'd1;
          end
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      job_r   <= 2'd0;
      col_r   <= '0;
      row_r   <= '0;
      win_a_r <= '0;
      win_b_r <= '0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
      if (state_r == S_DONE) begin
        win_a_r <= win_b_r;
        win_b_r <= cur;
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + RW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r <= {in_data.in_red, in_data.in_green, in_data.in_blue};
    end
  end

  `BB3_ASSERT_NOW(a_eof_last, out_valid && out_data.end_of_frame, out_data.last_of_run, "end of frame without last of run")
  `BB3_ASSERT_NEXT(a_acc_read, accept, state_r == S_READ, "accepted pixel did not start a line store access")
  `BB3_ASSERT_NEXT(a_job_only, start, state_r == S_JOB || state_r == S_DONE, "job issued outside the job phase")

endmodule

>>> hw/rtl/bb3_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module bb3_ram #(
  parameter int W     = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/bb3_mean.sv
// window sum and divide unit: sums stage, then divide into the output register
// depends on bb3_pkg
module bb3_mean (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  bb3_pkg::mean_req_t req,
  input  bb3_pkg::col_t      col_a,
  input  bb3_pkg::col_t      col_b,
  input  bb3_pkg::col_t      col_c,
  output logic               ready,
  output logic               out_valid,
  input  logic               out_stall,
  output bb3_pkg::pix_out_t  out_data
);

  logic                         s1_v_r;
  logic [bb3_pkg::SUM_W-1:0]    s1_sum_r [3];
  logic [1:0]                   s1_code_r;
  bb3_pkg::mean_req_t           s1_req_r;
  logic                         out_v_r;
  bb3_pkg::pix_out_t            out_r;
  logic [bb3_pkg::SUM_W-1:0]    sum_nxt [3];
  logic [1:0]                   code_nxt;
  logic [bb3_pkg::SUM_W-1:0]    hv [3];
  logic                         move;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_nxt[ch] = '0;
      for (int rw = 0; rw < 3; rw++) begin
        if (rw != 0 || !req.first) begin
          sum_nxt[ch] = sum_nxt[ch] + bb3_pkg::SUM_W'(col_b[rw][23-8*ch -: 8])
                                    + bb3_pkg::SUM_W'(col_c[rw][23-8*ch -: 8]);
          if (req.use_a) begin
            sum_nxt[ch] = sum_nxt[ch] + bb3_pkg::SUM_W'(col_a[rw][23-8*ch -: 8]);
          end
        end
      end
    end
    if (req.use_a && !req.first) begin
      code_nxt = bb3_pkg::CNT9;
    end else if (req.use_a || !req.first) begin
      code_nxt = bb3_pkg::CNT6;
    end else begin
      code_nxt = bb3_pkg::CNT4;
    end
  end

  assign move  = s1_v_r && (!out_v_r || !out_stall);
  assign ready = !s1_v_r || move;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      hv[ch] = s1_req_r.halve ? (s1_sum_r[ch] >> 1) : s1_sum_r[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (start) begin
        s1_v_r <= 1'b1;
      end else if (move) begin
        s1_v_r <= 1'b0;
      end
      if (move) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s1_sum_r  <= sum_nxt;
      s1_code_r <= code_nxt;
      s1_req_r  <= req;
    end
    if (move) begin
      out_r.out_red      <= bb3_pkg::div_cnt(hv[0], s1_code_r);
      out_r.out_green    <= bb3_pkg::div_cnt(hv[1], s1_code_r);
      out_r.out_blue     <= bb3_pkg::div_cnt(hv[2], s1_code_r);
      out_r.out_col      <= s1_req_r.col;
      out_r.out_row      <= s1_req_r.row;
      out_r.last_of_run  <= s1_req_r.last;
      out_r.end_of_frame <= s1_req_r.eof;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
